// ===== rtl/assert_macros.svh =====
// Assertion macros for the JSON string unescaper.
// The including module must provide clk and rst_n (synchronous, active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper.
// Used by jsu_decode and json_string_unescape_utf8_core; no dependencies.
`default_nettype none

package jsu_pkg;

  localparam int unsigned BURST_MAX = 6;
  localparam logic [7:0]  LIMIT_RESET = 8'd63;

  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] PAIR_BASE  = 21'h10000;
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;

  typedef enum logic [6:0] {
    M_NORMAL  = 7'b0000001,
    M_ESC     = 7'b0000010,
    M_HEX     = 7'b0000100,
    M_WAIT_BS = 7'b0001000,
    M_WAIT_U  = 7'b0010000,
    M_LOW     = 7'b0100000,
    M_LOW_BAD = 7'b1000000
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_BADHEX = 2'd2
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  hex_cnt;
    logic [15:0] high_code;
    logic [15:0] low_code;
    logic [7:0]  written;
    logic        stopped;
    status_t     status;
  } jsu_state_t;

  // Results of one request, oldest byte at index 0.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] data;
    logic [2:0]                len;
    logic                      fin;
    status_t                   status_mid;
    status_t                   status_end;
    logic [7:0]                base;
  } burst_t;

  localparam jsu_state_t ST_RESET = '{
    mode:      M_NORMAL,
    hex_cnt:   3'd0,
    high_code: 16'h0000,
    low_code:  16'h0000,
    written:   8'd0,
    stopped:   1'b0,
    status:    ST_OK
  };

endpackage

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// Per-byte decode step: escape state machine, UTF-8 encoding and output limit.
// Combinational; depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  jsu_pkg::jsu_state_t st,
  input  logic [7:0]          din,
  input  logic                fin,
  input  logic [7:0]          limit,
  output jsu_pkg::jsu_state_t st_nxt,
  output jsu_pkg::burst_t     burst
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = c[3:0];
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      r.val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF_HEX) || (c >= CH_UA && c <= CH_UF)) begin
      r.val = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_N) begin
      r = CH_LF;
    end else if (c == CH_T) begin
      r = CH_TAB;
    end else if (c == CH_R) begin
      r = CH_CR;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic utf8_t raw_enc(input logic [7:0] c);
    utf8_t r;
    r.b    = '0;
    r.len  = 3'd1;
    r.b[0] = c;
    return r;
  endfunction

  hex_t       hx;
  logic [15:0] high_sh, low_sh;
  logic [2:0]  cnt_inc;
  logic        last_digit;
  logic [20:0] pair_cp;
  logic [7:0]  room, rem1, written_end;

  jsu_state_t nx;
  logic        use1, raw1, use2, raw2, chk;
  logic [7:0]  byte1, byte2;
  logic [20:0] cp1, cp2;
  logic        trunc0, stop0, bad0, bad2;
  utf8_t       s1, s2;
  logic [2:0]  n1_req, n2_req, e1, e2;
  logic        chk_fail, trunc, bad;
  status_t     status_end;

  assign hx         = hex_val(din);
  assign high_sh    = {st.high_code[11:0], hx.val};
  assign low_sh     = {st.low_code[11:0], hx.val};
  assign cnt_inc    = st.hex_cnt + 3'd1;
  assign last_digit = cnt_inc >= 3'd4;
  assign pair_cp    = PAIR_BASE + {1'b0, st.high_code[9:0], low_sh[9:0]};
  assign room       = (st.written >= limit) ? 8'd0 : limit - st.written;

  // Escape state machine: pick up to two characters to write.
  always_comb begin
    nx     = st;
    use1   = 1'b0;
    raw1   = 1'b0;
    byte1  = din;
    cp1    = '0;
    use2   = 1'b0;
    raw2   = 1'b0;
    byte2  = din;
    cp2    = '0;
    chk    = 1'b0;
    trunc0 = 1'b0;
    stop0  = 1'b0;
    bad0   = 1'b0;
    bad2   = 1'b0;
    if (!st.stopped) begin
      case (st.mode)
        M_NORMAL: begin
          if (room == 8'd0) begin
            stop0  = 1'b1;
            trunc0 = 1'b1;
          end else if (din == CH_BSLASH && !fin) begin
            nx.mode = M_ESC;
          end else begin
            use1 = 1'b1;
            raw1 = 1'b1;
          end
        end
        M_ESC: begin
          if (din == CH_U) begin
            nx.high_code = '0;
            nx.hex_cnt   = '0;
            if (fin) begin
              use1    = 1'b1;
              raw1    = 1'b1;
              byte1   = CH_NUL;
              nx.mode = M_NORMAL;
            end else begin
              nx.mode = M_HEX;
            end
          end else begin
            use1    = 1'b1;
            raw1    = 1'b1;
            byte1   = esc_map(din);
            nx.mode = M_NORMAL;
          end
        end
        M_HEX: begin
          if (!hx.ok) begin
            bad0    = 1'b1;
            nx.mode = M_NORMAL;
          end else begin
            nx.high_code = high_sh;
            nx.hex_cnt   = cnt_inc;
            if (last_digit || fin) begin
              if (high_sh >= SUR_HI_MIN && high_sh <= SUR_HI_MAX && !fin) begin
                nx.mode = M_WAIT_BS;
              end else begin
                use1    = 1'b1;
                cp1     = (high_sh >= SUR_HI_MIN && high_sh <= SUR_LO_MAX) ?
                          REPL_CP : {5'b0, high_sh};
                nx.mode = M_NORMAL;
              end
            end
          end
        end
        M_WAIT_BS: begin
          if (din == CH_BSLASH && !fin) begin
            nx.mode = M_WAIT_U;
          end else begin
            use1    = 1'b1;
            cp1     = REPL_CP;
            nx.mode = M_NORMAL;
            chk     = 1'b1;
            use2    = 1'b1;
            raw2    = 1'b1;
          end
        end
        M_WAIT_U: begin
          if (din == CH_U && !fin) begin
            nx.mode     = M_LOW;
            nx.low_code = '0;
            nx.hex_cnt  = '0;
          end else begin
            use1    = 1'b1;
            cp1     = REPL_CP;
            nx.mode = M_NORMAL;
            chk     = 1'b1;
            use2    = 1'b1;
            raw2    = 1'b1;
            // a cut \u right at the end decodes to U+0000
            byte2   = (din == CH_U) ? CH_NUL : esc_map(din);
          end
        end
        M_LOW: begin
          nx.hex_cnt = cnt_inc;
          if (!hx.ok) begin
            nx.mode = M_LOW_BAD;
          end else begin
            nx.low_code = low_sh;
          end
          if (last_digit) begin
            use1    = 1'b1;
            cp1     = (hx.ok && low_sh >= SUR_LO_MIN && low_sh <= SUR_LO_MAX) ?
                      pair_cp : REPL_CP;
            nx.mode = M_NORMAL;
          end else if (fin) begin
            use1    = 1'b1;
            cp1     = REPL_CP;
            nx.mode = M_NORMAL;
            chk     = 1'b1;
            if (!hx.ok) begin
              bad2 = 1'b1;
            end else begin
              use2 = 1'b1;
              cp2  = {5'b0, low_sh};
            end
          end
        end
        M_LOW_BAD: begin
          nx.hex_cnt = cnt_inc;
          if (last_digit) begin
            use1    = 1'b1;
            cp1     = REPL_CP;
            nx.mode = M_NORMAL;
          end else if (fin) begin
            use1    = 1'b1;
            cp1     = REPL_CP;
            nx.mode = M_NORMAL;
            chk     = 1'b1;
            bad2    = 1'b1;
          end
        end
        default: begin
          nx.mode = M_NORMAL;
        end
      endcase
    end
  end

  // Apply the output limit: bytes past it drop, a character may be cut.
  always_comb begin
    s1     = raw1 ? raw_enc(byte1) : utf8_enc(cp1);
    s2     = raw2 ? raw_enc(byte2) : utf8_enc(cp2);
    n1_req = use1 ? s1.len : 3'd0;
    e1     = ({5'b0, n1_req} > room) ? room[2:0] : n1_req;
    rem1   = room - {5'b0, e1};
    chk_fail = chk && (rem1 == 8'd0);
    n2_req = (use2 && !chk_fail) ? s2.len : 3'd0;
    e2     = ({5'b0, n2_req} > rem1) ? rem1[2:0] : n2_req;
    bad    = bad0 || (bad2 && !chk_fail);
    trunc  = trunc0 || ({5'b0, n1_req} > room) || chk_fail || ({5'b0, n2_req} > rem1);
    written_end = st.written + {5'b0, e1} + {5'b0, e2};

    status_end = st.status;
    if (trunc && st.status == ST_OK) begin
      status_end = ST_TRUNC;
    end
    if (bad) begin
      status_end = ST_BADHEX;
    end
  end

  always_comb begin
    jsu_state_t upd;
    upd         = nx;
    upd.status  = status_end;
    upd.written = written_end;
    upd.stopped = st.stopped || stop0 || chk_fail || bad;
    if (bad) begin
      upd.mode = M_NORMAL;
    end
    // a final byte returns all per-string state to reset
    st_nxt = fin ? ST_RESET : upd;
  end

  always_comb begin
    burst.data = '0;
    for (int k = 0; k < 4; k++) begin
      burst.data[k] = s1.b[k];
    end
    // a second character only follows a complete replacement character
    if (e2 != 3'd0) begin
      for (int k = 0; k < 3; k++) begin
        burst.data[k + 3] = s2.b[k];
      end
    end
    burst.len = e1 + e2;
    if (burst.len == 3'd0) begin
      burst.data = '0;
    end
    burst.fin        = fin;
    burst.status_mid = st.status;
    burst.status_end = status_end;
    burst.base       = st.written;
  end

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8_core.sv =====
// JSON string unescaper producing UTF-8 bytes, one raw content byte per request.
// An input register feeds one decode step (jsu_decode) whose results land in a
// six-byte result buffer that drains one result per cycle while out_ready is
// high, so plain text streams at one byte per cycle unless the output stalls; a
// request that yields several results (a \u escape: up to four bytes, six when a
// replacement character precedes a cut escape) holds the input while the result
// buffer drains. A result passes through the input register and the result
// buffer before it appears at the output. Depends on jsu_pkg, jsu_decode and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module json_string_unescape_utf8_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_text,
  output logic [1:0] out_status,
  output logic [7:0] out_written_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_output_limit
);
  import jsu_pkg::*;

  logic [7:0] limit_r;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;
  jsu_state_t st_r;
  jsu_state_t dec_st;
  burst_t     burst;

  logic [2:0]                rem_r, rem_nxt;
  logic                      marker_r;
  logic                      fin_r;
  logic [BURST_MAX-1:0][7:0] data_r;
  logic [7:0]                cnt_r;
  status_t                   status_mid_r;
  status_t                   status_end_r;

  logic fire, pop, last, in_take;

  jsu_decode u_dec (
    .st     (st_r),
    .din    (in_byte_r),
    .fin    (in_fin_r),
    .limit  (limit_r),
    .st_nxt (dec_st),
    .burst  (burst)
  );

  assign cfg_ready = 1'b1;
  assign last      = rem_r == 3'd1;
  assign out_valid = rem_r != 3'd0;
  assign pop       = out_valid && out_ready;
  // decode when the result buffer is empty or its last result leaves now
  assign fire      = in_vld_r && (rem_r == 3'd0 || (last && out_ready));
  assign in_ready  = !in_vld_r || fire;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    rem_nxt = rem_r;
    if (fire) begin
      if (burst.len != 3'd0) begin
        rem_nxt = burst.len;
      end else begin
        rem_nxt = burst.fin ? 3'd1 : 3'd0;
      end
    end else if (pop) begin
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      in_vld_r <= 1'b0;
      st_r     <= ST_RESET;
      rem_r    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_output_limit;
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        st_r <= dec_st;
      end
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_fin_r  <= in_is_final;
    end
    if (fire) begin
      data_r       <= burst.data;
      marker_r     <= burst.len == 3'd0;
      fin_r        <= burst.fin;
      cnt_r        <= (burst.len == 3'd0) ? burst.base : burst.base + 8'd1;
      status_mid_r <= burst.status_mid;
      status_end_r <= burst.status_end;
    end else if (pop) begin
      // advance to the next byte of the burst
      data_r <= data_r >> 8;
      cnt_r  <= cnt_r + 8'd1;
    end
  end

  assign out_byte          = data_r[0];
  assign out_byte_valid    = !marker_r;
  assign out_end_of_text   = fin_r && last;
  assign out_status        = (fin_r && last) ? status_end_r : status_mid_r;
  assign out_written_count = cnt_r;

  `JSU_ASSERT_NOW(a_stop_normal, st_r.stopped, st_r.mode == M_NORMAL, "stopped outside normal mode")
  `JSU_ASSERT_NOW(a_marker_alone, out_valid && marker_r, last && fin_r, "end marker not alone")
  `JSU_ASSERT_NEXT(a_count_step, pop && (rem_r > 3'd1),
                   out_written_count == 8'($past(out_written_count) + 8'd1),
                   "written count did not advance within a burst")

endmodule

`default_nettype wire
